// ===== rtl/lgi_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lgi_pkg: shared types and constants of the Lagrange interpolator
// Table size, fixed point format, datapath widths and the sequencer states.
// ----------------------------------------------------------------------------
package lgi_pkg;

   localparam int MAX_POINTS = 8;
   localparam int FRAC_BITS  = 16;
   localparam int VAL_W      = 64;
   localparam int COORD_W    = 16;
   localparam int IDX_W      = $clog2(MAX_POINTS);
   localparam int CNT_W      = $clog2(MAX_POINTS + 1);
   localparam int DIV_CNT_W  = $clog2(VAL_W);

   localparam logic CMD_STORE = 1'b0;
   localparam logic CMD_EVAL  = 1'b1;

   typedef enum logic [3:0] {
      S_IDLE,
      S_DUP_RI,
      S_DUP_RJ,
      S_DUP_CMP,
      S_EV_RI,
      S_EV_LI,
      S_EV_RJ,
      S_EV_MH,
      S_EV_M1,
      S_EV_M2,
      S_EV_M3,
      S_EV_DIV,
      S_EV_ACC,
      S_DONE
   } state_type;

endpackage

// ===== rtl/lgi_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lgi_div: serial unsigned divider
// Restoring division of a 64-bit magnitude by a 16-bit nonzero magnitude,
// one quotient bit per cycle. done pulses in the cycle after the last step.
// ----------------------------------------------------------------------------
module lgi_div (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  logic [lgi_pkg::VAL_W-1:0]         dividend,
   input  logic [lgi_pkg::COORD_W-1:0]       divisor,
   output logic                              done,
   output logic [lgi_pkg::VAL_W-1:0]         quotient
);

   logic                              run_ff, run_in;
   logic                              done_ff, done_in;
   logic [lgi_pkg::DIV_CNT_W-1:0]     cnt_ff, cnt_in;
   logic [lgi_pkg::COORD_W-1:0]       rem_ff, rem_in;
   logic [lgi_pkg::VAL_W-1:0]         quo_ff, quo_in;
   logic [lgi_pkg::COORD_W-1:0]       dsr_ff, dsr_in;
   logic [lgi_pkg::COORD_W:0]         trial;
   logic                              fits;

   assign trial = {rem_ff, quo_ff[lgi_pkg::VAL_W-1]};
   assign fits  = trial >= {1'b0, dsr_ff};

   always_comb begin
      run_in  = run_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dsr_in  = dsr_ff;
      if (start) begin
         run_in = 1'b1;
         cnt_in = '0;
         rem_in = '0;
         quo_in = dividend;
         dsr_in = divisor;
      end else if (run_ff) begin
         rem_in = fits ? lgi_pkg::COORD_W'(trial - {1'b0, dsr_ff})
                       : trial[lgi_pkg::COORD_W-1:0];
         quo_in = {quo_ff[lgi_pkg::VAL_W-2:0], fits};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == lgi_pkg::DIV_CNT_W'(lgi_pkg::VAL_W - 1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dsr_ff <= dsr_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

// ===== rtl/lagrange_interpolator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lagrange_interpolator: Lagrange polynomial evaluation over a point table
// Stores up to eight (x, y) points and evaluates the interpolating polynomial
// at a query x in signed Q.16 fixed point, with saturation and a flag for
// repeated x values.
// ----------------------------------------------------------------------------
// Usage: pulse start with req_cmd and its fields while busy is low. A store
// beat (req_cmd = 0) writes req_point_x/req_point_y into slot
// req_point_index and returns nothing. An evaluate beat
// (req_cmd = 1) holds busy high while the sequencer works and then shows one
// result beat for a single cycle on rsp_valid; the receiver cannot stall it
// and must take it then. Evaluation first compares every pair of used x
// values, then builds each term with n-1 multiply and divide steps; each
// step reads the operand, sets up, passes the upper and then the lower half
// of the term through the shared 32x16 multiplier and waits on the 64-step
// serial divider. Each term also reads its point, skips j = i and then
// accumulates. A point count of zero goes straight to the result beat. A
// count above eight is treated as eight. csr_write_data sets point_count
// and may be written only while the block is idle. Reading a slot never
// stored since reset gives an undefined result.
// ----------------------------------------------------------------------------
module lagrange_interpolator (
   input  logic                clock,
   input  logic                reset,
   // command channel
   input  logic                start,
   output logic                busy,
   input  logic                req_cmd,
   input  logic [2:0]          req_point_index,
   input  logic signed [15:0]  req_point_x,
   input  logic signed [15:0]  req_point_y,
   input  logic signed [15:0]  req_query_x,
   // result channel
   output logic                rsp_valid,
   output logic signed [63:0]  rsp_interp_value,
   output logic                rsp_div_zero,
   output logic                rsp_saturated,
   // configuration
   input  logic                csr_write_en,
   input  logic [3:0]          csr_write_data
);

   localparam int VW = lgi_pkg::VAL_W;
   localparam int CW = lgi_pkg::COORD_W;
   localparam int HW = lgi_pkg::VAL_W / 2;
   localparam int PW = HW + lgi_pkg::COORD_W;
   localparam logic [VW-1:0] MIN_MAG = {1'b1, {(VW-1){1'b0}}};
   localparam logic [VW-1:0] MAX_MAG = {1'b0, {(VW-1){1'b1}}};

   lgi_pkg::state_type state_ff, state_in;

   // point table
   logic signed [CW-1:0] x_store_ff [lgi_pkg::MAX_POINTS];
   logic signed [CW-1:0] y_store_ff [lgi_pkg::MAX_POINTS];
   logic signed [CW-1:0] rd_x_ff, rd_y_ff;
   logic [lgi_pkg::IDX_W-1:0] rd_addr;

   logic [3:0]                 cfg_count_ff;
   logic [lgi_pkg::CNT_W-1:0]  n_eff;
   logic [lgi_pkg::CNT_W-1:0]  n_ff, n_in;
   logic [lgi_pkg::CNT_W-1:0]  i_ff, i_in;
   logic [lgi_pkg::CNT_W-1:0]  j_ff, j_in;
   logic [lgi_pkg::CNT_W-1:0]  i_next, j_next, i_skip2;

   logic signed [CW-1:0] q_ff, q_in;
   logic signed [CW-1:0] xi_ff, xi_in;
   logic [VW-1:0]        term_ff, term_in;
   logic [VW-1:0]        am_ff, am_in;
   logic [CW-1:0]        bm_ff, bm_in;
   logic [CW-1:0]        dm_ff, dm_in;
   logic                 mneg_ff, mneg_in;
   logic                 qneg_ff, qneg_in;
   logic [PW-1:0]        hi_ff, hi_in;
   logic [PW-1:0]        lo_ff, lo_in;
   logic [VW-1:0]        sum_ff, sum_in;
   logic                 sat_ff, sat_in;
   logic                 dz_ff, dz_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic [VW-1:0]        rsp_value_ff, rsp_value_in;
   logic                 rsp_dz_ff, rsp_dz_in;
   logic                 rsp_sat_ff, rsp_sat_in;

   logic                 accept;
   logic [CW:0]          fac_a, fac_d;
   logic [VW-1:0]        term_mag;
   logic [HW-1:0]        mul_a;
   logic [PW-1:0]        mul_prod;
   logic [VW-1:0]        prod_full;
   logic                 hsat, psat;
   logic [VW-1:0]        div_dividend;
   logic                 div_start, div_done;
   logic [VW-1:0]        div_quo;
   logic [VW-1:0]        term_div;
   logic [VW:0]          acc_sum;
   logic                 acc_ovf;

   assign accept = start && (state_ff == lgi_pkg::S_IDLE);
   assign busy   = (state_ff != lgi_pkg::S_IDLE);

   assign n_eff = (int'(cfg_count_ff) > lgi_pkg::MAX_POINTS)
                ? lgi_pkg::CNT_W'(lgi_pkg::MAX_POINTS)
                : lgi_pkg::CNT_W'(cfg_count_ff);

   assign i_next  = i_ff + 1'b1;
   assign j_next  = j_ff + 1'b1;
   assign i_skip2 = i_ff + lgi_pkg::CNT_W'(2);

   // factors (q - xj) and (xi - xj), 17-bit signed
   assign fac_a    = {q_ff[CW-1], q_ff} - {rd_x_ff[CW-1], rd_x_ff};
   assign fac_d    = {xi_ff[CW-1], xi_ff} - {rd_x_ff[CW-1], rd_x_ff};
   assign term_mag = term_ff[VW-1] ? (VW'(0) - term_ff) : term_ff;

   // shared 32x16 multiplier, upper half of the term first
   assign mul_a    = (state_ff == lgi_pkg::S_EV_M1) ? am_ff[VW-1:HW] : am_ff[HW-1:0];
   assign mul_prod = {{CW{1'b0}}, mul_a} * {{HW{1'b0}}, bm_ff};

   // recombine halves; clamp the product magnitude to the signed range
   assign prod_full    = {hi_ff[HW-1:0], {HW{1'b0}}} + {{(VW-PW){1'b0}}, lo_ff};
   assign hsat         = |hi_ff[PW-1:HW-1];
   assign psat         = mneg_ff ? (prod_full > MIN_MAG) : prod_full[VW-1];
   assign div_dividend = (hsat || psat) ? (mneg_ff ? MIN_MAG : MAX_MAG) : prod_full;

   // signed quotient; a positive 2^63 clamps without a flag
   assign term_div = (!qneg_ff && div_quo[VW-1]) ? MAX_MAG
                   : (qneg_ff ? (VW'(0) - div_quo) : div_quo);

   assign acc_sum = {sum_ff[VW-1], sum_ff} + {term_ff[VW-1], term_ff};
   assign acc_ovf = acc_sum[VW] ^ acc_sum[VW-1];

   lgi_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (dm_ff),
      .done     (div_done),
      .quotient (div_quo)
   );

   // ---------------------------------------------------------------- next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         lgi_pkg::S_IDLE: begin
            if (accept && req_cmd == lgi_pkg::CMD_EVAL) begin
               if (n_eff == '0) begin
                  state_in = lgi_pkg::S_DONE;
               end else if (n_eff == lgi_pkg::CNT_W'(1)) begin
                  state_in = lgi_pkg::S_EV_RI;
               end else begin
                  state_in = lgi_pkg::S_DUP_RI;
               end
            end
         end
         lgi_pkg::S_DUP_RI:  state_in = lgi_pkg::S_DUP_RJ;
         lgi_pkg::S_DUP_RJ:  state_in = lgi_pkg::S_DUP_CMP;
         lgi_pkg::S_DUP_CMP: begin
            if (rd_x_ff == xi_ff) begin
               state_in = lgi_pkg::S_DONE;
            end else if (j_next < n_ff || i_skip2 < n_ff) begin
               state_in = lgi_pkg::S_DUP_RI;
            end else begin
               state_in = lgi_pkg::S_EV_RI;
            end
         end
         lgi_pkg::S_EV_RI: state_in = lgi_pkg::S_EV_LI;
         lgi_pkg::S_EV_LI: state_in = lgi_pkg::S_EV_RJ;
         lgi_pkg::S_EV_RJ: begin
            if (j_ff >= n_ff) begin
               state_in = lgi_pkg::S_EV_ACC;
            end else if (j_ff != i_ff) begin
               state_in = lgi_pkg::S_EV_MH;
            end
         end
         lgi_pkg::S_EV_MH: state_in = lgi_pkg::S_EV_M1;
         lgi_pkg::S_EV_M1: state_in = lgi_pkg::S_EV_M2;
         lgi_pkg::S_EV_M2: state_in = lgi_pkg::S_EV_M3;
         lgi_pkg::S_EV_M3: state_in = lgi_pkg::S_EV_DIV;
         lgi_pkg::S_EV_DIV: begin
            if (div_done) begin
               state_in = lgi_pkg::S_EV_RJ;
            end
         end
         lgi_pkg::S_EV_ACC: begin
            state_in = (i_next < n_ff) ? lgi_pkg::S_EV_RI : lgi_pkg::S_DONE;
         end
         lgi_pkg::S_DONE: state_in = lgi_pkg::S_IDLE;
         default:         state_in = lgi_pkg::S_IDLE;
      endcase
   end

   // ---------------------------------------------------------------- datapath
   always_comb begin
      n_in         = n_ff;
      i_in         = i_ff;
      j_in         = j_ff;
      q_in         = q_ff;
      xi_in        = xi_ff;
      term_in      = term_ff;
      am_in        = am_ff;
      bm_in        = bm_ff;
      dm_in        = dm_ff;
      mneg_in      = mneg_ff;
      qneg_in      = qneg_ff;
      hi_in        = hi_ff;
      lo_in        = lo_ff;
      sum_in       = sum_ff;
      sat_in       = sat_ff;
      dz_in        = dz_ff;
      rsp_valid_in = 1'b0;
      rsp_value_in = rsp_value_ff;
      rsp_dz_in    = rsp_dz_ff;
      rsp_sat_in   = rsp_sat_ff;
      rd_addr      = i_ff[lgi_pkg::IDX_W-1:0];
      div_start    = 1'b0;
      case (state_ff)
         lgi_pkg::S_IDLE: begin
            if (accept && req_cmd == lgi_pkg::CMD_EVAL) begin
               q_in   = req_query_x;
               n_in   = n_eff;
               i_in   = '0;
               j_in   = lgi_pkg::CNT_W'(1);
               sum_in = '0;
               sat_in = 1'b0;
               dz_in  = 1'b0;
            end
         end
         lgi_pkg::S_DUP_RI: begin
            rd_addr = i_ff[lgi_pkg::IDX_W-1:0];
         end
         lgi_pkg::S_DUP_RJ: begin
            xi_in   = rd_x_ff;
            rd_addr = j_ff[lgi_pkg::IDX_W-1:0];
         end
         lgi_pkg::S_DUP_CMP: begin
            if (rd_x_ff == xi_ff) begin
               dz_in = 1'b1;
            end else if (j_next < n_ff) begin
               j_in = j_next;
            end else if (i_skip2 < n_ff) begin
               i_in = i_next;
               j_in = i_skip2;
            end else begin
               i_in = '0;
            end
         end
         lgi_pkg::S_EV_RI: begin
            rd_addr = i_ff[lgi_pkg::IDX_W-1:0];
         end
         lgi_pkg::S_EV_LI: begin
            xi_in   = rd_x_ff;
            term_in = VW'(rd_y_ff) <<< lgi_pkg::FRAC_BITS;
            j_in    = '0;
         end
         lgi_pkg::S_EV_RJ: begin
            rd_addr = j_ff[lgi_pkg::IDX_W-1:0];
            if (j_ff < n_ff && j_ff == i_ff) begin
               j_in = j_next;
            end
         end
         lgi_pkg::S_EV_MH: begin
            am_in   = term_mag;
            bm_in   = fac_a[CW] ? CW'(-fac_a) : fac_a[CW-1:0];
            dm_in   = fac_d[CW] ? CW'(-fac_d) : fac_d[CW-1:0];
            mneg_in = term_ff[VW-1] ^ fac_a[CW];
            qneg_in = term_ff[VW-1] ^ fac_a[CW] ^ fac_d[CW];
         end
         lgi_pkg::S_EV_M1: begin
            hi_in = mul_prod;
         end
         lgi_pkg::S_EV_M2: begin
            lo_in = mul_prod;
         end
         lgi_pkg::S_EV_M3: begin
            div_start = 1'b1;
            sat_in    = sat_ff | hsat | psat;
         end
         lgi_pkg::S_EV_DIV: begin
            if (div_done) begin
               term_in = term_div;
               j_in    = j_next;
            end
         end
         lgi_pkg::S_EV_ACC: begin
            if (acc_ovf) begin
               sum_in = acc_sum[VW] ? MIN_MAG : MAX_MAG;
               sat_in = 1'b1;
            end else begin
               sum_in = acc_sum[VW-1:0];
            end
            i_in = i_next;
         end
         lgi_pkg::S_DONE: begin
            rsp_valid_in = 1'b1;
            rsp_value_in = dz_ff ? '0 : sum_ff;
            rsp_dz_in    = dz_ff;
            rsp_sat_in   = sat_ff & ~dz_ff;
         end
         default: begin
            rd_addr = i_ff[lgi_pkg::IDX_W-1:0];
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= lgi_pkg::S_IDLE;
         cfg_count_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write_en) begin
            cfg_count_ff <= csr_write_data;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      n_ff         <= n_in;
      i_ff         <= i_in;
      j_ff         <= j_in;
      q_ff         <= q_in;
      xi_ff        <= xi_in;
      term_ff      <= term_in;
      am_ff        <= am_in;
      bm_ff        <= bm_in;
      dm_ff        <= dm_in;
      mneg_ff      <= mneg_in;
      qneg_ff      <= qneg_in;
      hi_ff        <= hi_in;
      lo_ff        <= lo_in;
      sum_ff       <= sum_in;
      sat_ff       <= sat_in;
      dz_ff        <= dz_in;
      rsp_value_ff <= rsp_value_in;
      rsp_dz_ff    <= rsp_dz_in;
      rsp_sat_ff   <= rsp_sat_in;
   end

   // point table: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (accept && req_cmd == lgi_pkg::CMD_STORE &&
          int'(req_point_index) < lgi_pkg::MAX_POINTS) begin
         x_store_ff[lgi_pkg::IDX_W'(req_point_index)] <= req_point_x;
         y_store_ff[lgi_pkg::IDX_W'(req_point_index)] <= req_point_y;
      end
      rd_x_ff <= x_store_ff[rd_addr];
      rd_y_ff <= y_store_ff[rd_addr];
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_interp_value = rsp_value_ff;
   assign rsp_div_zero     = rsp_dz_ff;
   assign rsp_saturated    = rsp_sat_ff;

`ifndef NO_ASSERTIONS
   // a result beat is a single-cycle strobe
   a_rsp_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe held for two cycles");

   // the result appears only after the sequencer has gone idle
   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("result shown while busy");

   // a repeated x gives a zero value with no saturation
   a_dz_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_div_zero) |-> (rsp_interp_value == '0 && !rsp_saturated))
      else $error("divide-by-zero result not cleared");

   // divider finishes only while the sequencer waits on it
   a_div_wait: assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == lgi_pkg::S_EV_DIV))
      else $error("divider done outside divide wait");
`endif

endmodule
